[hw/rtl/pca_pkg.sv]
package pca_pkg;

  // Pipeline depth from input acceptance to the output register.
  localparam int unsigned NumStages = 8;

  // Stage positions along the pipeline.
  localparam int unsigned StBright = 0;
  localparam int unsigned StConMul = 1;
  localparam int unsigned StConClp = 2;
  localparam int unsigned StGray   = 3;
  localparam int unsigned StSatMul = 4;
  localparam int unsigned StSatClp = 5;
  localparam int unsigned StHueMul = 6;
  localparam int unsigned StHueSum = 7;

  // Widths of the configuration port and the intermediate values.
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 15;
  localparam int unsigned GainW    = 12;
  localparam int unsigned CoefW    = 15;
  localparam int unsigned OffW     = 9;
  localparam int unsigned GainPrdW = 21;
  localparam int unsigned SatSumW  = 22;
  localparam int unsigned HuePrdW  = 24;
  localparam int unsigned ClampW   = 26;

  // Luma weights of 0.299, 0.587 and 0.114 in Q0.16; they sum to 65536.
  localparam logic [15:0] GrayWr = 16'd19595;
  localparam logic [15:0] GrayWg = 16'd38470;
  localparam logic [15:0] GrayWb = 16'd7471;

  // Register indexes of the configuration port.
  typedef enum logic [CfgIdxW-1:0] {
    RegBrightOffset = 3'd0,
    RegContrastGain = 3'd1,
    RegSatGain      = 3'd2,
    RegHueDiag      = 3'd3,
    RegHueCoefB     = 3'd4,
    RegHueCoefC     = 3'd5,
    RegHueCoefD     = 3'd6
  } cfg_idx_e;

  // Per-stage load enables and valid bits.
  typedef struct packed {
    logic [NumStages-1:0] en;
    logic [NumStages-1:0] valid;
  } pca_pipe_t;

  // Saturate a signed value to the 0..255 pixel range.
  function automatic logic [7:0] clamp_u8(input logic signed [ClampW-1:0] v);
    logic [7:0] r;
    if (v < 0) begin
      r = 8'd0;
    end else if (v > 255) begin
      r = 8'd255;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

endpackage

[hw/rtl/pca_if.sv]
// Input pixel channel.
interface pca_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  logic [7:0] alpha_in;

  modport source (output valid, output red_in, output green_in, output blue_in,
                  output alpha_in, input ready);
  modport sink   (input valid, input red_in, input green_in, input blue_in,
                  input alpha_in, output ready);
endinterface

// Output pixel channel.
interface pca_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic [7:0] alpha_out;

  modport source (output valid, output red_out, output green_out, output blue_out,
                  output alpha_out, input ready);
  modport sink   (input valid, input red_out, input green_out, input blue_out,
                  input alpha_out, output ready);
endinterface

[hw/rtl/pca_ctrl.sv]
module pca_ctrl
  import pca_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  logic      out_ready_i,
  output pca_pipe_t pipe_o
);

  logic [NumStages-1:0] valid_q;
  logic [NumStages-1:0] valid_d;
  logic [NumStages-1:0] rdy;

  // A stage may load when it is empty or its content moves on this cycle.
  always_comb begin
    rdy[NumStages-1] = ~valid_q[NumStages-1] | out_ready_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      rdy[k] = ~valid_q[k] | rdy[k+1];
    end
  end

  // Valid bits follow the data one stage per load.
  always_comb begin
    valid_d = valid_q;
    if (rdy[0]) begin
      valid_d[0] = in_valid_i;
    end
    for (int k = 1; k < NumStages; k++) begin
      if (rdy[k]) begin
        valid_d[k] = valid_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_ready_o   = rdy[0];
  assign pipe_o.en    = rdy;
  assign pipe_o.valid = valid_q;

endmodule

[hw/rtl/pixel_color_adjust_chain_top.sv]
// Channel   Dir  Payload                                   Handshake
// in_chan   in   red_in, green_in, blue_in, alpha_in       valid/ready
// out_chan  out  red_out, green_out, blue_out, alpha_out   valid/ready
// cfg       in   cfg_idx_i (3b), cfg_data_i (15b)          cfg_we_i, no wait
//
// One pixel is accepted per cycle unless the pipeline is full and stalled;
// pixels pass the eight-stage pipeline of adder, multiplier and clamp stages.
// Reset clears the valid bits and loads the default register values.
// Each stage holds its pixel only while the stage after it is full and stalled,
// so bubbles close up and a stalled output does not block input until full.
module pixel_color_adjust_chain_top
  import pca_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  pca_in_if.sink              in_chan,
  pca_out_if.source           out_chan,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  // Configuration registers.
  logic signed [OffW-1:0]  bright_q;
  logic        [GainW-1:0] con_gain_q;
  logic        [GainW-1:0] sat_gain_q;
  logic signed [CoefW-1:0] coef_a_q;
  logic signed [CoefW-1:0] coef_b_q;
  logic signed [CoefW-1:0] coef_c_q;
  logic signed [CoefW-1:0] coef_d_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bright_q   <= '0;
      con_gain_q <= GainW'(256);
      sat_gain_q <= GainW'(256);
      coef_a_q   <= CoefW'(4096);
      coef_b_q   <= '0;
      coef_c_q   <= '0;
      coef_d_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        RegBrightOffset: bright_q   <= cfg_data_i[OffW-1:0];
        RegContrastGain: con_gain_q <= cfg_data_i[GainW-1:0];
        RegSatGain:      sat_gain_q <= cfg_data_i[GainW-1:0];
        RegHueDiag:      coef_a_q   <= cfg_data_i[CoefW-1:0];
        RegHueCoefB:     coef_b_q   <= cfg_data_i[CoefW-1:0];
        RegHueCoefC:     coef_c_q   <= cfg_data_i[CoefW-1:0];
        RegHueCoefD:     coef_d_q   <= cfg_data_i[CoefW-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline control.
  pca_pipe_t pipe;

  pca_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_chan.valid),
    .in_ready_o (in_chan.ready),
    .out_ready_i(out_chan.ready),
    .pipe_o     (pipe)
  );

  // Datapath registers.
  logic        [7:0]          alpha_q [NumStages];
  logic        [7:0]          br_q    [3];
  logic signed [GainPrdW-1:0] cp_q    [3];
  logic        [7:0]          cc_q    [3];
  logic        [7:0]          gc_q    [3];
  logic        [7:0]          gray_q;
  logic signed [GainPrdW-1:0] sp_q    [3];
  logic        [7:0]          gray_s_q;
  logic        [7:0]          sc_q    [3];
  logic signed [HuePrdW-1:0]  hp_q    [3][3];
  logic        [7:0]          out_q   [3];

  logic        [7:0]          br_d    [3];
  logic signed [GainPrdW-1:0] cp_d    [3];
  logic        [7:0]          cc_d    [3];
  logic        [7:0]          gray_d;
  logic signed [GainPrdW-1:0] sp_d    [3];
  logic        [7:0]          sc_d    [3];
  logic signed [HuePrdW-1:0]  hp_d    [3][3];
  logic        [7:0]          out_d   [3];
  logic        [7:0]          pix_in  [3];
  logic signed [CoefW-1:0]    coef    [3][3];

  assign pix_in[0] = in_chan.red_in;
  assign pix_in[1] = in_chan.green_in;
  assign pix_in[2] = in_chan.blue_in;

  // Brightness offset and clamp.
  always_comb begin
    logic signed [OffW:0] s;
    for (int i = 0; i < 3; i++) begin
      s = $signed({2'b00, pix_in[i]}) + (OffW + 1)'(bright_q);
      br_d[i] = clamp_u8(ClampW'(s));
    end
  end

  // Contrast product about mid gray.
  always_comb begin
    logic signed [GainPrdW-1:0] d;
    logic signed [GainPrdW-1:0] g;
    g = $signed({{(GainPrdW-GainW){1'b0}}, con_gain_q});
    for (int i = 0; i < 3; i++) begin
      d = $signed({{(GainPrdW-8){1'b0}}, br_q[i]}) - GainPrdW'(128);
      cp_d[i] = d * g;
    end
  end

  // Contrast mid-gray offset back in, shift and clamp.
  always_comb begin
    logic signed [SatSumW-1:0] v;
    for (int i = 0; i < 3; i++) begin
      v = SatSumW'(cp_q[i]) + SatSumW'(32768);
      cc_d[i] = clamp_u8(ClampW'(v >>> 8));
    end
  end

  // Luma gray from the weighted sum.
  always_comb begin
    logic [23:0] s;
    s = 24'(GrayWr * cc_q[0]) + 24'(GrayWg * cc_q[1]) + 24'(GrayWb * cc_q[2]);
    gray_d = s[23:16];
  end

  // Saturation product of the distance from gray.
  always_comb begin
    logic signed [GainPrdW-1:0] d;
    logic signed [GainPrdW-1:0] g;
    g = $signed({{(GainPrdW-GainW){1'b0}}, sat_gain_q});
    for (int i = 0; i < 3; i++) begin
      d = $signed({{(GainPrdW-8){1'b0}}, gc_q[i]})
        - $signed({{(GainPrdW-8){1'b0}}, gray_q});
      sp_d[i] = d * g;
    end
  end

  // Saturation recombination with gray, shift and clamp.
  always_comb begin
    logic signed [SatSumW-1:0] v;
    for (int i = 0; i < 3; i++) begin
      v = $signed({{(SatSumW-16){1'b0}}, gray_s_q, 8'h00}) + SatSumW'(sp_q[i]);
      sc_d[i] = clamp_u8(ClampW'(v >>> 8));
    end
  end

  // Hue matrix laid out from the four coefficients, coef_a_q on the diagonal.
  always_comb begin
    coef[0][0] = coef_a_q; coef[0][1] = coef_b_q; coef[0][2] = coef_c_q;
    coef[1][0] = coef_d_q; coef[1][1] = coef_a_q; coef[1][2] = coef_b_q;
    coef[2][0] = coef_b_q; coef[2][1] = coef_d_q; coef[2][2] = coef_a_q;
  end

  // Hue matrix products.
  always_comb begin
    logic signed [HuePrdW-1:0] c;
    for (int r = 0; r < 3; r++) begin
      for (int j = 0; j < 3; j++) begin
        c = $signed({{(HuePrdW-8){1'b0}}, sc_q[j]});
        hp_d[r][j] = c * HuePrdW'(coef[r][j]);
      end
    end
  end

  // Hue row sums, shift and clamp.
  always_comb begin
    logic signed [ClampW-1:0] s;
    for (int r = 0; r < 3; r++) begin
      s = ClampW'(hp_q[r][0]) + ClampW'(hp_q[r][1]) + ClampW'(hp_q[r][2]);
      out_d[r] = clamp_u8(s >>> 12);
    end
  end

  // Stage registers load on their enables.
  always_ff @(posedge clk_i) begin
    if (pipe.en[StBright]) begin
      br_q             <= br_d;
      alpha_q[StBright] <= in_chan.alpha_in;
    end
    if (pipe.en[StConMul]) begin
      cp_q <= cp_d;
    end
    if (pipe.en[StConClp]) begin
      cc_q <= cc_d;
    end
    if (pipe.en[StGray]) begin
      gray_q <= gray_d;
      gc_q   <= cc_q;
    end
    if (pipe.en[StSatMul]) begin
      sp_q     <= sp_d;
      gray_s_q <= gray_q;
    end
    if (pipe.en[StSatClp]) begin
      sc_q <= sc_d;
    end
    if (pipe.en[StHueMul]) begin
      hp_q <= hp_d;
    end
    if (pipe.en[StHueSum]) begin
      out_q <= out_d;
    end
    for (int k = 1; k < NumStages; k++) begin
      if (pipe.en[k]) begin
        alpha_q[k] <= alpha_q[k-1];
      end
    end
  end

  // Output channel.
  assign out_chan.valid     = pipe.valid[NumStages-1];
  assign out_chan.red_out   = out_q[0];
  assign out_chan.green_out = out_q[1];
  assign out_chan.blue_out  = out_q[2];
  assign out_chan.alpha_out = alpha_q[NumStages-1];

endmodule

[bench/pca_checker.sv]
package pca_tb_pkg;

  // One RGBA pixel as it travels on either channel.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pixel_t;

endpackage

module pca_checker import pca_pkg::*, pca_tb_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  pca_in_if                   in_chan,
  pca_out_if                  out_chan,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output int unsigned         fail_count_o,
  output int unsigned         pending_o,
  output int unsigned         checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Luma weights in Q0.16.
  localparam int LumaWr = 19595;
  localparam int LumaWg = 38470;
  localparam int LumaWb = 7471;

  // Shadow copy of the adjustment registers.
  logic signed [OffW-1:0]  bright_off;
  logic [GainW-1:0]        con_gain;
  logic [GainW-1:0]        sat_gain;
  logic signed [CoefW-1:0] hue_diag;
  logic signed [CoefW-1:0] hue_b;
  logic signed [CoefW-1:0] hue_c;
  logic signed [CoefW-1:0] hue_d;

  pixel_t      adjusted_q[$];
  pixel_t      got_px;
  pixel_t      want_px;
  int unsigned n_fail;
  int unsigned n_checked;

  // Lane names in the bit order of pixel_t, lowest byte first.
  string lane_name [4] = '{"alpha", "blue", "green", "red"};

  // Negative values give 0; otherwise shift down and saturate at 255.
  function automatic int shift_sat(int v, int sh);
    int r;
    if (v < 0) begin
      r = 0;
    end else begin
      r = v >>> sh;
      if (r > 255) r = 255;
    end
    return r;
  endfunction

  // Brightness, contrast, saturation and hue matrix, in pipeline order.
  function automatic pixel_t adjust_pixel(pixel_t px);
    int     ch [3];
    int     hue [3];
    int     gray;
    pixel_t res;
    ch[0] = px.red;
    ch[1] = px.green;
    ch[2] = px.blue;
    for (int i = 0; i < 3; i++) begin
      ch[i] = shift_sat(ch[i] + int'(bright_off), 0);
      ch[i] = shift_sat((ch[i] - 128) * int'(con_gain) + 128 * 256, 8);
    end
    gray = (LumaWr * ch[0] + LumaWg * ch[1] + LumaWb * ch[2]) >>> 16;
    for (int i = 0; i < 3; i++) begin
      ch[i] = shift_sat(gray * 256 + (ch[i] - gray) * int'(sat_gain), 8);
    end
    hue[0] = ch[0] * int'(hue_diag) + ch[1] * int'(hue_b) + ch[2] * int'(hue_c);
    hue[1] = ch[0] * int'(hue_d) + ch[1] * int'(hue_diag) + ch[2] * int'(hue_b);
    hue[2] = ch[0] * int'(hue_b) + ch[1] * int'(hue_d) + ch[2] * int'(hue_diag);
    res.red   = 8'(shift_sat(hue[0], 12));
    res.green = 8'(shift_sat(hue[1], 12));
    res.blue  = 8'(shift_sat(hue[2], 12));
    res.alpha = px.alpha;
    return res;
  endfunction

  // Watch both channels and the register port at every rising edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bright_off = '0;
      con_gain   = GainW'(256);
      sat_gain   = GainW'(256);
      hue_diag   = CoefW'(4096);
      hue_b      = '0;
      hue_c      = '0;
      hue_d      = '0;
      adjusted_q.delete();
      n_fail     = 0;
      n_checked  = 0;
    end else begin
      // Compare a delivered pixel with the oldest prediction.
      if (out_chan.valid && out_chan.ready) begin
        got_px = {out_chan.red_out, out_chan.green_out, out_chan.blue_out,
                  out_chan.alpha_out};
        if (adjusted_q.size() == 0) begin
          $display("%0t: output pixel with nothing expected, expected none, actual %h",
                   $time, got_px);
          n_fail++;
        end else begin
          want_px = adjusted_q.pop_front();
          for (int i = 0; i < 4; i++) begin
            if (got_px[8*i +: 8] !== want_px[8*i +: 8]) begin
              $display("%0t: %s mismatch, expected %0d, actual %0d", $time,
                       lane_name[i], want_px[8*i +: 8], got_px[8*i +: 8]);
              n_fail++;
            end
          end
          n_checked++;
        end
      end

      // Predict each accepted input pixel with the current settings.
      if (in_chan.valid && in_chan.ready) begin
        adjusted_q.push_back(adjust_pixel({in_chan.red_in, in_chan.green_in,
                                           in_chan.blue_in, in_chan.alpha_in}));
      end

      // Register writes keep only the width of the target register.
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegBrightOffset: bright_off = cfg_data_i[OffW-1:0];
          RegContrastGain: con_gain   = cfg_data_i[GainW-1:0];
          RegSatGain:      sat_gain   = cfg_data_i[GainW-1:0];
          RegHueDiag:      hue_diag   = cfg_data_i[CoefW-1:0];
          RegHueCoefB:     hue_b      = cfg_data_i[CoefW-1:0];
          RegHueCoefC:     hue_c      = cfg_data_i[CoefW-1:0];
          RegHueCoefD:     hue_d      = cfg_data_i[CoefW-1:0];
          default: ;
        endcase
      end
    end
    fail_count_o <= n_fail;
    pending_o    <= adjusted_q.size();
    checked_o    <= n_checked;
  end

endmodule

[bench/tb_pixel_color_adjust_chain_top.sv]
module tb_pixel_color_adjust_chain_top import pca_pkg::*, pca_tb_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          ClkPeriod     = 20;
  localparam int          CycleLimit    = 200000;
  localparam int          RandPhases    = 8;
  localparam int          ItemsPerPhase = 162;
  localparam int          TailCycles    = 2 * NumStages;
  localparam int          NumRegs       = 7;
  // Index past the end of the register list; writes to it are dropped.
  localparam logic [CfgIdxW-1:0] RegUnused = 3'd7;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  int unsigned fail_count;
  int unsigned pending_cnt;
  int unsigned checked_cnt;
  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned n_sent;
  int unsigned n_settings;
  int unsigned cycle_cnt = 0;

  // Values to load into the registers, indexed by register.
  logic [CfgDataW-1:0] reg_val [NumRegs];

  pca_in_if  in_chan ();
  pca_out_if out_chan ();

  pixel_color_adjust_chain_top u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_chan    (in_chan),
    .out_chan   (out_chan),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  pca_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_chan      (in_chan),
    .out_chan     (out_chan),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (pending_cnt),
    .checked_o    (checked_cnt)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  // Output side: stall at random with the current percentage.
  initial begin
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_chan.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Hang guard.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic pixel_t mk_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                      logic [7:0] a);
    return '{red: r, green: g, blue: b, alpha: a};
  endfunction

  function automatic logic [CfgDataW-1:0] cfg_val(int v);
    return v[CfgDataW-1:0];
  endfunction

  // Uniform in lo..hi, with an optional bias toward the two ends.
  function automatic logic [CfgDataW-1:0] pick_in(int lo, int hi, bit with_ends);
    int v;
    v = lo + int'($urandom_range(hi - lo));
    if (with_ends && $urandom_range(3) == 0) v = $urandom_range(1) ? hi : lo;
    return cfg_val(v);
  endfunction

  // Mostly random pixels, sometimes with channels pinned to black or white.
  function automatic pixel_t rand_pixel();
    pixel_t p;
    p = $urandom;
    if ($urandom_range(7) == 0) begin
      if ($urandom_range(1)) p.red = $urandom_range(1) ? 8'hFF : 8'h00;
      if ($urandom_range(1)) p.green = $urandom_range(1) ? 8'hFF : 8'h00;
      if ($urandom_range(1)) p.blue = $urandom_range(1) ? 8'hFF : 8'h00;
    end
    return p;
  endfunction

  task automatic drive_fields(pixel_t p);
    in_chan.red_in   <= p.red;
    in_chan.green_in <= p.green;
    in_chan.blue_in  <= p.blue;
    in_chan.alpha_in <= p.alpha;
  endtask

  // Offer one pixel after a random gap and wait until it is taken.
  task automatic send_pixel(pixel_t p);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      in_chan.valid <= 1'b0;
      drive_fields(pixel_t'($urandom));
      @(negedge clk_i);
    end
    in_chan.valid <= 1'b1;
    drive_fields(p);
    @(posedge clk_i);
    while (!in_chan.ready) @(posedge clk_i);
    n_sent++;
  endtask

  // Stop offering and wait until every predicted pixel has come out.
  task automatic drain();
    @(negedge clk_i);
    in_chan.valid <= 1'b0;
    while (pending_cnt != 0) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  task automatic load_settings();
    for (int i = 0; i < NumRegs; i++) cfg_write(cfg_idx_e'(i), reg_val[i]);
    n_settings++;
  endtask

  task automatic set_identity();
    reg_val[RegBrightOffset] = cfg_val(0);
    reg_val[RegContrastGain] = cfg_val(256);
    reg_val[RegSatGain]      = cfg_val(256);
    reg_val[RegHueDiag]      = cfg_val(4096);
    reg_val[RegHueCoefB]     = cfg_val(0);
    reg_val[RegHueCoefC]     = cfg_val(0);
    reg_val[RegHueCoefD]     = cfg_val(0);
  endtask

  task automatic set_max();
    reg_val[RegBrightOffset] = cfg_val(255);
    reg_val[RegContrastGain] = cfg_val(4095);
    reg_val[RegSatGain]      = cfg_val(4095);
    reg_val[RegHueDiag]      = cfg_val(16383);
    reg_val[RegHueCoefB]     = cfg_val(-16384);
    reg_val[RegHueCoefC]     = cfg_val(16383);
    reg_val[RegHueCoefD]     = cfg_val(-16384);
  endtask

  task automatic set_min();
    reg_val[RegBrightOffset] = cfg_val(-255);
    reg_val[RegContrastGain] = cfg_val(0);
    reg_val[RegSatGain]      = cfg_val(0);
    reg_val[RegHueDiag]      = cfg_val(-16384);
    reg_val[RegHueCoefB]     = cfg_val(16383);
    reg_val[RegHueCoefC]     = cfg_val(-16384);
    reg_val[RegHueCoefD]     = cfg_val(16383);
  endtask

  // Either a mild, near-identity look or anything across the full ranges.
  task automatic set_random();
    if ($urandom_range(1)) begin
      reg_val[RegBrightOffset] = pick_in(-64, 64, 1'b0);
      reg_val[RegContrastGain] = pick_in(128, 512, 1'b0);
      reg_val[RegSatGain]      = pick_in(0, 512, 1'b0);
      reg_val[RegHueDiag]      = pick_in(2560, 5632, 1'b0);
      reg_val[RegHueCoefB]     = pick_in(-2048, 2048, 1'b0);
      reg_val[RegHueCoefC]     = pick_in(-2048, 2048, 1'b0);
      reg_val[RegHueCoefD]     = pick_in(-2048, 2048, 1'b0);
    end else begin
      reg_val[RegBrightOffset] = pick_in(-256, 255, 1'b1);
      reg_val[RegContrastGain] = pick_in(0, 4095, 1'b1);
      reg_val[RegSatGain]      = pick_in(0, 4095, 1'b1);
      reg_val[RegHueDiag]      = pick_in(-16384, 16383, 1'b1);
      reg_val[RegHueCoefB]     = pick_in(-16384, 16383, 1'b1);
      reg_val[RegHueCoefC]     = pick_in(-16384, 16383, 1'b1);
      reg_val[RegHueCoefD]     = pick_in(-16384, 16383, 1'b1);
    end
  endtask

  // Stimulus: directed pixels under edge settings, then random phases.
  initial begin
    in_chan.valid    = 1'b0;
    in_chan.red_in   = '0;
    in_chan.green_in = '0;
    in_chan.blue_in  = '0;
    in_chan.alpha_in = '0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = '0;
    cfg_data_i       = '0;
    idle_pct         = 0;
    stall_pct        = 0;
    n_sent           = 0;
    n_settings       = 1;
    rst_ni           = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings leave every pixel unchanged.
    send_pixel(mk_pixel(8'd0, 8'd0, 8'd0, 8'd0));
    send_pixel(mk_pixel(8'd255, 8'd255, 8'd255, 8'd255));
    send_pixel(mk_pixel(8'd255, 8'd0, 8'd0, 8'h5A));
    send_pixel(mk_pixel(8'd0, 8'd255, 8'd0, 8'hA5));
    send_pixel(mk_pixel(8'd0, 8'd0, 8'd255, 8'h0F));
    send_pixel(mk_pixel(8'd128, 8'd128, 8'd128, 8'hF0));
    send_pixel(mk_pixel(8'h55, 8'hAA, 8'h55, 8'hAA));
    send_pixel(mk_pixel(8'hAA, 8'h55, 8'hAA, 8'h55));
    send_pixel(mk_pixel(8'd1, 8'd254, 8'd127, 8'd128));
    drain();

    // Offset pattern of -256 with junk in the upper data bits, plus a write
    // to an index that does not exist.
    set_identity();
    reg_val[RegBrightOffset] = 15'h7F00;
    load_settings();
    cfg_write(RegUnused, 15'h7FFF);
    send_pixel(mk_pixel(8'd255, 8'd255, 8'd255, 8'd1));
    send_pixel(mk_pixel(8'd10, 8'd200, 8'd90, 8'd2));
    drain();

    // Offset, gains and hue diagonal at their top values, hue terms at opposite extremes.
    set_max();
    load_settings();
    send_pixel(mk_pixel(8'd0, 8'd0, 8'd0, 8'd3));
    send_pixel(mk_pixel(8'd255, 8'd255, 8'd255, 8'd4));
    send_pixel(mk_pixel(8'd255, 8'd0, 8'd128, 8'd5));
    send_pixel(mk_pixel(8'd3, 8'd77, 8'd200, 8'd6));
    drain();

    // Offset at -255, gains and hue diagonal at their bottom values, other hue terms opposite.
    set_min();
    load_settings();
    send_pixel(mk_pixel(8'd0, 8'd0, 8'd0, 8'd7));
    send_pixel(mk_pixel(8'd255, 8'd255, 8'd255, 8'd8));
    send_pixel(mk_pixel(8'd100, 8'd150, 8'd200, 8'd9));
    drain();

    // A typical look: slight lift, more contrast and saturation, hue turn.
    reg_val[RegBrightOffset] = cfg_val(20);
    reg_val[RegContrastGain] = cfg_val(384);
    reg_val[RegSatGain]      = cfg_val(300);
    reg_val[RegHueDiag]      = cfg_val(2731);
    reg_val[RegHueCoefB]     = cfg_val(-1365);
    reg_val[RegHueCoefC]     = cfg_val(2731);
    reg_val[RegHueCoefD]     = cfg_val(2731);
    load_settings();
    send_pixel(mk_pixel(8'd200, 8'd40, 8'd90, 8'd10));
    send_pixel(mk_pixel(8'd30, 8'd180, 8'd220, 8'd11));
    send_pixel(mk_pixel(8'd128, 8'd64, 8'd32, 8'd12));
    send_pixel(mk_pixel(8'd250, 8'd250, 8'd5, 8'd13));
    drain();

    // Random phases cycle through the idle and stall patterns.
    for (int phase = 0; phase < RandPhases; phase++) begin
      case (phase % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 76; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 76; end
        default: begin idle_pct = 9; stall_pct = 9; end
      endcase
      case (phase)
        0: set_identity();
        1: set_max();
        2: set_min();
        default: set_random();
      endcase
      load_settings();
      repeat (ItemsPerPhase) send_pixel(rand_pixel());
      drain();
    end

    repeat (TailCycles) @(posedge clk_i);
    $display("Sent %0d pixels under %0d register settings; %0d results compared.",
             n_sent, n_settings, checked_cnt);
    $display("Idle patterns: none, input gaps, output stalls, and both together.");
    if (fail_count == 0 && pending_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
